/* src/scmd_pkg.sv */
// Package with shared types and constants of the servo command line parser.
package scmd_pkg;

  localparam int unsigned NumCap  = 131071;
  localparam int unsigned PosCap  = 15;
  localparam int unsigned NumW    = 17;

  typedef enum logic [3:0] {
    KIND_INVALID      = 4'd0,
    KIND_SAFE         = 4'd1,
    KIND_RUN          = 4'd2,
    KIND_STOP         = 4'd3,
    KIND_HEARTBEAT    = 4'd4,
    KIND_INPUT_READ   = 4'd5,
    KIND_INPUT_GUARD  = 4'd6,
    KIND_HELLO        = 4'd7,
    KIND_SERVO_READ   = 4'd8,
    KIND_SERVO_ENABLE = 4'd9,
    KIND_SERVO_TARGET = 4'd10
  } kind_e;

  typedef enum logic [0:0] {
    REG_SPEED_LIMIT = 1'b0,
    REG_ACCEL_LIMIT = 1'b1
  } reg_idx_e;

  // One classified character, passed from the front end to the back end.
  typedef struct packed {
    logic [7:0] code;
    logic       present;
    logic       eol;
  } char_word_t;

  // One finished command.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  servo_id;
    logic        enable_flag;
    logic [11:0] position;
    logic [15:0] speed;
    logic [7:0]  acceleration;
    logic [5:0]  guard_mask;
    logic [5:0]  guard_high;
    logic [7:0]  hello_version;
  } result_t;

  // Upper-cased keyword letter at a position; 0 beyond the word.
  function automatic logic [7:0] first_letter(input logic [2:0] w, input logic [3:0] p);
    logic [8*9-1:0] s;
    logic [3:0]     n;
    begin
      case (w)
        3'd0:    begin s = {"SAFE", 40'd0};      n = 4'd4; end
        3'd1:    begin s = {"RUN", 48'd0};       n = 4'd3; end
        3'd2:    begin s = {"STOP", 40'd0};      n = 4'd4; end
        3'd3:    begin s = "HEARTBEAT";          n = 4'd9; end
        3'd4:    begin s = {"INPUT", 32'd0};     n = 4'd5; end
        3'd5:    begin s = {"HELLO", 32'd0};     n = 4'd5; end
        default: begin s = {"SERVO", 32'd0};     n = 4'd5; end
      endcase
      if (p < n) first_letter = s[8*(8-p[3:0]) +: 8];
      else first_letter = 8'd0;
    end
  endfunction

  function automatic logic [3:0] first_len(input logic [2:0] w);
    case (w)
      3'd0:    first_len = 4'd4;
      3'd1:    first_len = 4'd3;
      3'd2:    first_len = 4'd4;
      3'd3:    first_len = 4'd9;
      default: first_len = 4'd5;
    endcase
  endfunction

  function automatic logic [7:0] second_letter(input logic [1:0] w, input logic [3:0] p);
    logic [8*6-1:0] s;
    logic [3:0]     n;
    begin
      case (w)
        2'd0:    begin s = {"READ", 16'd0};  n = 4'd4; end
        2'd1:    begin s = {"GUARD", 8'd0};  n = 4'd5; end
        2'd2:    begin s = "ENABLE";         n = 4'd6; end
        default: begin s = "TARGET";         n = 4'd6; end
      endcase
      if (p < n && p < 4'd6) second_letter = s[8*(5-p[2:0]) +: 8];
      else second_letter = 8'd0;
    end
  endfunction

  function automatic logic [3:0] second_len(input logic [1:0] w);
    case (w)
      2'd0:    second_len = 4'd4;
      2'd1:    second_len = 4'd5;
      default: second_len = 4'd6;
    endcase
  endfunction

endpackage

/* src/scmd_front.sv */
// Front end: input handshake and a two-entry queue of classified characters.
module scmd_front
  import scmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] code_i,
  input  logic       present_i,
  input  logic       eol_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output char_word_t word_o,
  output logic       word_valid_o,
  input  logic       word_ready_i
);

  char_word_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  // Idle words change nothing, so they are dropped here.
  assign push         = in_valid_i && in_ready_o && (present_i || eol_i);
  assign word_valid_o = (cnt_q != 2'd0);
  assign pop          = word_valid_o && word_ready_i;
  assign word_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{code: code_i, present: present_i, eol: eol_i};
    end
  end

endmodule

/* src/scmd_back.sv */
// Back end: tokeniser, keyword matcher, number accumulators and command decoder.
module scmd_back
  import scmd_pkg::*;
#(
  parameter int unsigned TokenLimit = 6,
  parameter int unsigned DigitLimit = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  char_word_t  word_i,
  input  logic        word_valid_i,
  output logic        word_ready_o,
  input  logic [15:0] speed_limit_i,
  input  logic [7:0]  accel_limit_i,
  output result_t     res_o,
  output logic        res_valid_o,
  input  logic        res_ready_i
);

  localparam int unsigned CntW = $clog2(TokenLimit + 2);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_tok_q, in_tok_d;
  logic [3:0]      pos_q, pos_d;
  logic [6:0]      fh_q, fh_d;
  logic [3:0]      sh_q, sh_d;
  logic [NumW-1:0] num_q [5];
  logic [NumW-1:0] num_d [5];
  logic [4:0]      nv_q, nv_d;
  result_t         res_q, res_d;
  logic            rv_q, rv_d;
  logic            take;

  // A finished command waits in the output register while the next one forms;
  // only an end-of-line word has to wait for it to leave.
  assign word_ready_o = !rv_q || res_ready_i || !word_i.eol;
  assign take         = word_valid_i && word_ready_o;
  assign res_o        = res_q;
  assign res_valid_o  = rv_q;

  function automatic logic ok(input logic v, input logic [NumW-1:0] x,
                              input logic [NumW-1:0] m);
    ok = v && (x <= m);
  endfunction

  always_comb begin
    logic [7:0]      c, up;
    logic            sep;
    logic [CntW-1:0] idx;
    logic [NumW+3:0] prod;
    logic            fin;
    result_t         r;
    cnt_d = cnt_q; in_tok_d = in_tok_q; pos_d = pos_q;
    fh_d = fh_q; sh_d = sh_q; num_d = num_q; nv_d = nv_q;
    res_d = res_q; rv_d = rv_q && !res_ready_i;
    c   = word_i.code;
    sep = (c == 8'h20) || (c == 8'h09);
    up  = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    fin = 1'b0;
    idx = '0;
    prod = '0;
    r = '0;
    if (take && word_i.present) begin
      if (sep) begin
        fin = in_tok_q;
      end else begin
        if (!in_tok_q) begin
          in_tok_d = 1'b1;
          pos_d = 4'd0;
          if (cnt_q <= CntW'(TokenLimit)) cnt_d = cnt_q + 1'b1;
          for (int k = 0; k < 5; k++) begin
            if (cnt_d == CntW'(k + 2)) begin
              num_d[k] = '0;
              nv_d[k]  = 1'b1;
            end
          end
        end
        idx = cnt_d - 1'b1;
        if (idx == '0) begin
          for (int b = 0; b < 7; b++)
            if (first_letter(3'(b), pos_d) != up) fh_d[b] = 1'b0;
        end else if (idx == CntW'(1)) begin
          for (int b = 0; b < 4; b++)
            if (second_letter(2'(b), pos_d) != up) sh_d[b] = 1'b0;
        end
        for (int k = 0; k < 5; k++) begin
          if (idx == CntW'(k + 1) && nv_d[k]) begin
            if (c >= 8'h30 && c <= 8'h39) begin
              prod = {num_d[k], 3'd0} + {2'd0, num_d[k], 1'b0} + (NumW+4)'(c - 8'h30);
              num_d[k] = (prod > (NumW+4)'(NumCap)) ? NumW'(NumCap) : prod[NumW-1:0];
            end else begin
              nv_d[k] = 1'b0;
            end
          end
        end
        if (pos_d < 4'(PosCap)) pos_d = pos_d + 1'b1;
      end
    end
    if (take && word_i.eol && in_tok_d) fin = 1'b1;
    if (fin) begin
      idx = cnt_d - 1'b1;
      if (idx == '0) begin
        for (int b = 0; b < 7; b++) if (first_len(3'(b)) != pos_d) fh_d[b] = 1'b0;
      end else if (idx == CntW'(1)) begin
        for (int b = 0; b < 4; b++) if (second_len(2'(b)) != pos_d) sh_d[b] = 1'b0;
      end
      for (int k = 0; k < 5; k++)
        if (idx == CntW'(k + 1) && (pos_d < 4'd1 || pos_d > 4'(DigitLimit)))
          nv_d[k] = 1'b0;
      in_tok_d = 1'b0;
    end
    if (take && word_i.eol) begin
      r.kind = KIND_INVALID;
      if (cnt_d == CntW'(1)) begin
        if (fh_d[0]) r.kind = KIND_SAFE;
        else if (fh_d[1]) r.kind = KIND_RUN;
        else if (fh_d[2]) r.kind = KIND_STOP;
        else if (fh_d[3]) r.kind = KIND_HEARTBEAT;
      end else if (cnt_d == CntW'(2) && fh_d[4] && sh_d[0]) begin
        r.kind = KIND_INPUT_READ;
      end else if (cnt_d == CntW'(4) && fh_d[4] && sh_d[1]) begin
        if (ok(nv_d[1], num_d[1], NumW'(63)) && ok(nv_d[2], num_d[2], NumW'(63)) &&
            ((num_d[2] & ~num_d[1]) == '0)) begin
          r.kind = KIND_INPUT_GUARD;
          r.guard_mask = num_d[1][5:0];
          r.guard_high = num_d[2][5:0];
        end
      end else if (cnt_d == CntW'(2) && fh_d[5] && ok(nv_d[0], num_d[0], NumW'(255)) &&
                   num_d[0] != '0) begin
        r.kind = KIND_HELLO;
        r.hello_version = num_d[0][7:0];
      end else if (fh_d[6] && cnt_d >= CntW'(3) && cnt_d <= CntW'(6) &&
                   ok(nv_d[1], num_d[1], NumW'(253)) && num_d[1] != '0) begin
        if (cnt_d == CntW'(3) && sh_d[0]) begin
          r.kind = KIND_SERVO_READ;
          r.servo_id = num_d[1][7:0];
        end else if (cnt_d == CntW'(4) && sh_d[2] && ok(nv_d[2], num_d[2], NumW'(1))) begin
          r.kind = KIND_SERVO_ENABLE;
          r.servo_id = num_d[1][7:0];
          r.enable_flag = num_d[2][0];
        end else if (cnt_d == CntW'(6) && sh_d[3] && ok(nv_d[2], num_d[2], NumW'(4095)) &&
                     ok(nv_d[3], num_d[3], NumW'(speed_limit_i)) &&
                     ok(nv_d[4], num_d[4], NumW'(accel_limit_i))) begin
          r.kind = KIND_SERVO_TARGET;
          r.servo_id = num_d[1][7:0];
          r.position = num_d[2][11:0];
          r.speed = num_d[3][15:0];
          r.acceleration = num_d[4][7:0];
        end
      end
      res_d = r;
      rv_d  = 1'b1;
      cnt_d = '0; in_tok_d = 1'b0; pos_d = 4'd0;
      fh_d = 7'h7F; sh_d = 4'hF; nv_d = '0;
      for (int k = 0; k < 5; k++) num_d[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; in_tok_q <= 1'b0; pos_q <= 4'd0;
      fh_q <= 7'h7F; sh_q <= 4'hF; nv_q <= '0; rv_q <= 1'b0;
      for (int k = 0; k < 5; k++) num_q[k] <= '0;
    end else begin
      cnt_q <= cnt_d; in_tok_q <= in_tok_d; pos_q <= pos_d;
      fh_q <= fh_d; sh_q <= sh_d; nv_q <= nv_d; rv_q <= rv_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

/* src/servo_command_line_parser.sv */
// Top level of the servo command line parser.
// The parser takes one character word per cycle on the slave stream while
// s_axis_tready is high and sends one command word on the master stream for every
// word that ends a line. A front end takes words into a two-entry queue; the back
// end consumes one queued word per cycle unless an end-of-line word waits for the
// output register. m_axis_tvalid is registered: the end-of-line word leaves the
// queue and sets the output register. The finished command sits in an output
// register; the back end keeps consuming characters of the next line and only an
// end-of-line word waits while the previous command has not been taken, after which
// the queue fills and s_axis_tready falls. Words with neither a character nor an
// end-of-line mark are dropped. Keywords match regardless of case; the command
// kind travels on m_axis_tuser, unused fields are zero and a bad line gives kind
// zero.
module servo_command_line_parser
  import scmd_pkg::*;
#(
  parameter int unsigned TOKEN_LIMIT = 6,
  parameter int unsigned DIGIT_LIMIT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code [7:0]
  input  logic        s_axis_tuser,   // char_present
  input  logic        s_axis_tlast,   // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // servo_id[7:0] enable_flag[8] position[20:9] speed[36:21] acceleration[44:37]
  // guard_mask[50:45] guard_high[56:51] hello_version[64:57]
  output logic [71:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // kind [3:0]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  char_word_t  word;
  logic        word_valid, word_ready;
  result_t     res;
  logic [15:0] speed_limit_q;
  logic [7:0]  accel_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= 16'd4095;
      accel_limit_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPEED_LIMIT: speed_limit_q <= cfg_data_i;
        REG_ACCEL_LIMIT: accel_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  scmd_front u_front (
    .clk_i, .rst_ni,
    .code_i(s_axis_tdata), .present_i(s_axis_tuser), .eol_i(s_axis_tlast),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .word_o(word), .word_valid_o(word_valid), .word_ready_i(word_ready)
  );

  scmd_back #(.TokenLimit(TOKEN_LIMIT), .DigitLimit(DIGIT_LIMIT)) u_back (
    .clk_i, .rst_ni,
    .word_i(word), .word_valid_i(word_valid), .word_ready_o(word_ready),
    .speed_limit_i(speed_limit_q), .accel_limit_i(accel_limit_q),
    .res_o(res), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, res.hello_version, res.guard_high, res.guard_mask,
                         res.acceleration, res.speed, res.position, res.enable_flag,
                         res.servo_id};
  assign m_axis_tuser = res.kind;

endmodule

/* bench/servo_command_line_parser_tb.sv */
// Self-checking testbench of the servo command line parser.
// Command lines are sent one character word at a time on the slave stream. A
// line model in the bench predicts the command word that each line should give.
// Every command word taken from the master stream is checked field by field
// against the oldest predicted command. The tests run as tasks, one after the
// other: directed lines, limit register extremes, random lines under three idling
// mixes, a long hold-off on the master side, and a full drain in mid-stream.
`timescale 1ns / 1ps

module servo_command_line_parser_tb
  import scmd_pkg::*;
();

  localparam int unsigned TokenLimit = 6;
  localparam int unsigned DigitLimit = 10;
  localparam int unsigned ValueCap   = 131071;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_code [7:0]
  logic        s_axis_tuser = 1'b0; // char_present
  logic        s_axis_tlast = 1'b0; // end_of_line
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // servo_id[7:0] enable_flag[8] position[20:9] speed[36:21] acceleration[44:37]
  // guard_mask[50:45] guard_high[56:51] hello_version[64:57]
  logic [71:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;        // kind [3:0]
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  servo_command_line_parser DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line model: a copy of the parser state, updated for every accepted word.
  // ---------------------------------------------------------------------------
  string lead_words[7] = '{"SAFE", "RUN", "STOP", "HEARTBEAT", "INPUT", "HELLO", "SERVO"};
  string sub_words[4]  = '{"READ", "GUARD", "ENABLE", "TARGET"};

  int unsigned speed_max = 4095;
  int unsigned accel_max = 255;

  int unsigned tok_cnt;
  bit          in_tok;
  int unsigned char_pos;
  bit [6:0]    lead_hits;
  bit [3:0]    sub_hits;
  int unsigned num_val[5];
  bit          num_good[5];

  // Predicted commands, oldest first: the data word above the kind in [3:0].
  logic [75:0] cmd_queue[$];
  int          err_cnt = 0;
  int          words_sent = 0;

  function automatic void clear_line();
    tok_cnt   = 0;
    in_tok    = 1'b0;
    char_pos  = 0;
    lead_hits = '1;
    sub_hits  = '1;
    for (int k = 0; k < 5; k++) begin
      num_val[k]  = 0;
      num_good[k] = 1'b0;
    end
  endfunction

  function automatic void close_token();
    int unsigned idx;
    idx = tok_cnt - 1;
    // A keyword only survives if the token ended exactly at its length.
    if (idx == 0) begin
      for (int b = 0; b < 7; b++) if (char_pos != lead_words[b].len()) lead_hits[b] = 1'b0;
    end else if (idx == 1) begin
      for (int b = 0; b < 4; b++) if (char_pos != sub_words[b].len()) sub_hits[b] = 1'b0;
    end
    if (idx >= 1 && idx <= 5 && (char_pos < 1 || char_pos > DigitLimit))
      num_good[idx-1] = 1'b0;
    in_tok = 1'b0;
  endfunction

  function automatic void take_char(byte unsigned c);
    int unsigned idx;
    int unsigned up;
    int unsigned v;
    if (c == 8'h20 || c == 8'h09) begin
      if (in_tok) close_token();
      return;
    end
    if (!in_tok) begin
      in_tok   = 1'b1;
      char_pos = 0;
      if (tok_cnt <= TokenLimit) tok_cnt++;
      idx = tok_cnt - 1;
      if (idx >= 1 && idx <= 5) begin
        num_val[idx-1]  = 0;
        num_good[idx-1] = 1'b1;
      end
    end
    idx = tok_cnt - 1;
    up  = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
    if (idx == 0) begin
      for (int b = 0; b < 7; b++)
        if (char_pos >= lead_words[b].len() || lead_words[b][char_pos] != up)
          lead_hits[b] = 1'b0;
    end else if (idx == 1) begin
      for (int b = 0; b < 4; b++)
        if (char_pos >= sub_words[b].len() || sub_words[b][char_pos] != up)
          sub_hits[b] = 1'b0;
    end
    if (idx >= 1 && idx <= 5 && num_good[idx-1]) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        v = num_val[idx-1] * 10 + (c - 8'h30);
        num_val[idx-1] = (v > ValueCap) ? ValueCap : v;
      end else begin
        num_good[idx-1] = 1'b0;
      end
    end
    if (char_pos < 15) char_pos++;
  endfunction

  // Token numbering counts from zero along the line: token 1 is the first after the keyword.
  function automatic bit tok_ok(int unsigned tok, int unsigned maximum);
    return num_good[tok-1] && num_val[tok-1] <= maximum;
  endfunction

  function automatic logic [75:0] close_line();
    kind_e       kind;
    logic [7:0]  id, ver;
    logic        en;
    logic [11:0] pos;
    logic [15:0] spd;
    logic [7:0]  acc;
    logic [5:0]  gm, gh;
    int unsigned n;
    kind = KIND_INVALID;
    {id, ver, en, pos, spd, acc, gm, gh} = '0;
    if (in_tok) close_token();
    n = tok_cnt;
    if (n >= 1 && n <= 6) begin
      if (n == 1) begin
        if (lead_hits[0])      kind = KIND_SAFE;
        else if (lead_hits[1]) kind = KIND_RUN;
        else if (lead_hits[2]) kind = KIND_STOP;
        else if (lead_hits[3]) kind = KIND_HEARTBEAT;
      end else if (n == 2 && lead_hits[4] && sub_hits[0]) begin
        kind = KIND_INPUT_READ;
      end else if (n == 4 && lead_hits[4] && sub_hits[1]) begin
        // The required-high bits must lie inside the mask.
        if (tok_ok(2, 63) && tok_ok(3, 63) && (num_val[2] & ~num_val[1]) == 0) begin
          kind = KIND_INPUT_GUARD;
          gm   = 6'(num_val[1]);
          gh   = 6'(num_val[2]);
        end
      end else if (n == 2 && lead_hits[5] && tok_ok(1, 255) && num_val[0] > 0) begin
        kind = KIND_HELLO;
        ver  = 8'(num_val[0]);
      end else if (lead_hits[6] && n >= 3 && tok_ok(2, 253) && num_val[1] > 0) begin
        if (n == 3 && sub_hits[0]) begin
          kind = KIND_SERVO_READ;
          id   = 8'(num_val[1]);
        end else if (n == 4 && sub_hits[2] && tok_ok(3, 1)) begin
          kind = KIND_SERVO_ENABLE;
          id   = 8'(num_val[1]);
          en   = num_val[2][0];
        end else if (n == 6 && sub_hits[3] && tok_ok(3, 4095) && tok_ok(4, speed_max) &&
                     tok_ok(5, accel_max)) begin
          kind = KIND_SERVO_TARGET;
          id   = 8'(num_val[1]);
          pos  = 12'(num_val[2]);
          spd  = 16'(num_val[3]);
          acc  = 8'(num_val[4]);
        end
      end
    end
    clear_line();
    return {7'd0, ver, gh, gm, acc, spd, pos, en, id, kind};
  endfunction

  // ---------------------------------------------------------------------------
  // Slave side: one word per call, idling at random before it.
  // ---------------------------------------------------------------------------
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  task automatic send_word(byte unsigned c, bit present, bit eol);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (present) take_char(c);
    if (eol) cmd_queue.push_back(close_line());
  endtask

  // Sends a line; the end mark rides on the last character or on a bare word.
  // Words that carry nothing are sprinkled in now and then.
  task automatic send_line(string text);
    bit bare_end;
    bare_end = (text.len() == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < text.len(); i++) begin
      if ($urandom_range(19) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(text[i], 1'b1, !bare_end && i == text.len() - 1);
    end
    if (bare_end) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Registers change only with the parser idle, after the last command has been taken.
  task automatic write_limits(int unsigned spd, int unsigned acc);
    stop_sending();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SPEED_LIMIT;
    cfg_data_i <= 16'(spd);
    @(posedge clk_i);
    cfg_idx_i  <= REG_ACCEL_LIMIT;
    cfg_data_i <= 16'(acc);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    speed_max  = spd;
    accel_max  = acc;
  endtask

  // ---------------------------------------------------------------------------
  // Master side: random stalls, a long hold-off on request, and the checker.
  // ---------------------------------------------------------------------------
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: %s is %0d, expected %0d", $realtime, field, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    logic [75:0] want;
    logic [71:0] exp_data;
    if (m_axis_tvalid && m_axis_tready) begin
      if (cmd_queue.size() == 0) begin
        report_mismatch("kind of an unexpected command word", m_axis_tuser, 0);
      end else begin
        want = cmd_queue.pop_front();
        exp_data = want[75:4];
        if (m_axis_tuser !== want[3:0])
          report_mismatch("kind", m_axis_tuser, want[3:0]);
        if (m_axis_tdata[7:0] !== exp_data[7:0])
          report_mismatch("servo_id", m_axis_tdata[7:0], exp_data[7:0]);
        if (m_axis_tdata[8] !== exp_data[8])
          report_mismatch("enable_flag", m_axis_tdata[8], exp_data[8]);
        if (m_axis_tdata[20:9] !== exp_data[20:9])
          report_mismatch("position", m_axis_tdata[20:9], exp_data[20:9]);
        if (m_axis_tdata[36:21] !== exp_data[36:21])
          report_mismatch("speed", m_axis_tdata[36:21], exp_data[36:21]);
        if (m_axis_tdata[44:37] !== exp_data[44:37])
          report_mismatch("acceleration", m_axis_tdata[44:37], exp_data[44:37]);
        if (m_axis_tdata[50:45] !== exp_data[50:45])
          report_mismatch("guard_mask", m_axis_tdata[50:45], exp_data[50:45]);
        if (m_axis_tdata[56:51] !== exp_data[56:51])
          report_mismatch("guard_high", m_axis_tdata[56:51], exp_data[56:51]);
        if (m_axis_tdata[64:57] !== exp_data[64:57])
          report_mismatch("hello_version", m_axis_tdata[64:57], exp_data[64:57]);
      end
    end
    // One long hold-off for each request.
    if (!hold_req) hold_seen = 1'b0;
    if (hold_req && !hold_seen) begin
      hold_left = 300;
      hold_seen = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Random line content.
  // ---------------------------------------------------------------------------
  function automatic string mixed_case(string w);
    string s;
    s = w;
    for (int i = 0; i < s.len(); i++) if ($urandom_range(1)) s[i] = s[i] + 8'h20;
    return s;
  endfunction

  function automatic string blanks();
    string s;
    s = "";
    for (int i = 0; i < $urandom_range(2, 1); i++) s = {s, $urandom_range(1) ? " " : "\t"};
    return s;
  endfunction

  // Mostly values up to the given limit or just past it, sometimes padded or overlong.
  function automatic string number_text(int unsigned limit);
    string s;
    int unsigned v;
    case ($urandom_range(9))
      0:       v = limit;
      1:       v = limit + 1;
      2:       v = 0;
      3: begin
        s = "";
        for (int i = 0; i < $urandom_range(12, 9); i++) s = {s, $sformatf("%0d", $urandom_range(9))};
        return s;
      end
      default: v = $urandom_range(limit);
    endcase
    s = $sformatf("%0d", v);
    if ($urandom_range(5) == 0) s = {"00", s};
    return s;
  endfunction

  function automatic string random_line();
    string tok[$];
    string line;
    int unsigned m, h;
    case ($urandom_range(10))
      0: tok.push_back(lead_words[$urandom_range(3)]);
      1: tok = '{"INPUT", "READ"};
      2: begin
        m = $urandom_range(63);
        h = $urandom_range(1) ? ($urandom_range(63) & m) : $urandom_range(63);
        tok = '{"INPUT", "GUARD", $sformatf("%0d", m), $sformatf("%0d", h)};
        if ($urandom_range(3) == 0) tok[2] = number_text(63);
      end
      3: tok = '{"HELLO", number_text(255)};
      4: tok = '{"SERVO", "READ", number_text(253)};
      5: tok = '{"SERVO", "ENABLE", number_text(253), number_text(1)};
      6, 7: tok = '{"SERVO", "TARGET", number_text(253), number_text(4095),
                   number_text(speed_max), number_text(accel_max)};
      default: begin
        // Noise: random tokens of random bytes, up to eight of them.
        for (int t = 0; t < $urandom_range(8); t++) begin
          line = "";
          for (int i = 0; i < $urandom_range(17, 1); i++) begin
            m = $urandom_range(255);
            line = {line, (m == 8'h20 || m == 8'h09 || m == 0) ? "x" : string'(byte'(m))};
          end
          tok.push_back(line);
        end
      end
    endcase
    for (int t = 0; t < tok.size() && t < 2; t++) tok[t] = mixed_case(tok[t]);
    // Broken sequences: a stray byte, a dropped token or an extra one.
    if ($urandom_range(7) == 0 && tok.size() > 0) begin
      m = $urandom_range(tok.size() - 1);
      if (tok[m].len() > 0)
        tok[m][$urandom_range(tok[m].len() - 1)] = byte'($urandom_range(1, 255));
    end
    if ($urandom_range(15) == 0 && tok.size() > 0) tok.pop_back();
    if ($urandom_range(15) == 0) tok.push_back("7");
    line = $urandom_range(3) == 0 ? blanks() : "";
    foreach (tok[t]) line = {line, tok[t], (t == tok.size() - 1) ? "" : blanks()};
    if ($urandom_range(3) == 0) line = {line, blanks()};
    return line;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_line("SAFE");
    send_line("run");
    send_line("\tsToP  ");
    send_line("HeartBeat");
    send_line("INPUT READ");
    send_line("input guard 63 63");
    send_line("INPUT GUARD 5 6");            // high bits outside the mask
    send_line("HELLO 255");
    send_line("HELLO 0");
    send_line("servo read 253");
    send_line("SERVO READ 254");
    send_line("SERVO ENABLE 1 0000000001");
    send_line("SERVO ENABLE 1 2");
    send_line("SERVO TARGET 1 4095 4095 255");
    send_line("SERVO TARGET 1 4096 0 0");
    send_line("SERVO TARGET 1 0 0 00000000000");  // eleven digits is too long
    send_line("SERVO TARGET 1 2 3 99999999999");  // value saturates, still too big
    send_line("SAFE 1 2 3 4 5 6");                // seven tokens
    send_line("");
    send_line("   \t ");
    send_line("SAFEXXXXXXXXXXXXXXXXXXX");         // overlong token
    send_line({"SAF", string'(byte'(8'hc5))});    // high codes are plain text
    send_line("HEARTBEATS");
    send_word(8'hff, 1'b0, 1'b0);                 // idle word, ignored
    send_line("RUN");
  endtask

  task automatic test_limits();
    write_limits(0, 0);
    send_line("SERVO TARGET 9 100 0 0");
    send_line("SERVO TARGET 9 100 1 0");
    send_line("SERVO TARGET 9 100 0 1");
    write_limits(65535, 255);
    send_line("SERVO TARGET 253 4095 65535 255");
    send_line("SERVO TARGET 253 4095 65536 255");
    write_limits(1234, 17);
    for (int i = 0; i < 6; i++) send_line(random_line());
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, int words);
    int goal;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    goal = words_sent + words;
    while (words_sent < goal) send_line(random_line());
  endtask

  task automatic test_hold_off();
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++) send_line("SERVO TARGET 12 345 678 90");
    hold_req = 1'b0;
    stop_sending();
    send_line("SERVO READ 1");
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    clear_line();
    test_directed();
    test_limits();
    write_limits(4095, 255);
    test_random(31, 68, 50);
    write_limits($urandom_range(65535), $urandom_range(255));
    test_random(68, 31, 50);
    test_hold_off();
    test_random(0, 0, 50);
    stop_sending();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* servo_command_line_parser.f */
src/scmd_pkg.sv
src/scmd_front.sv
src/scmd_back.sv
src/servo_command_line_parser.sv
bench/servo_command_line_parser_tb.sv
